[src/hvd_pkg.sv]
// shared constants, widths and constant functions for the haversine distance pipeline
package hvd_pkg;

    localparam int ANGLE_FRAC_BITS   = 30;
    localparam int CORDIC_STEPS_DEF  = 32;
    localparam int ANG_W             = 36;
    localparam int UNIT_W            = 33;
    localparam int PROD_W            = 2 * UNIT_W;
    localparam int A_W               = 32;
    localparam int SQ_W              = 64;
    localparam int ROOT_W            = 32;
    localparam int SQRT_STEPS        = 32;
    localparam int LAT_W             = 31;
    localparam int LON_W             = 32;
    localparam int RADIUS_W          = 24;
    localparam int DIST_W            = 26;
    localparam int MAG_W             = 32;
    localparam int ZC_W              = 32;
    localparam int DPROD_W           = RADIUS_W + ZC_W + 1;
    localparam int ANGLE_SH          = 60 - ANGLE_FRAC_BITS;
    localparam int DIST_SH           = ANGLE_FRAC_BITS - 1;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd6371000;
    localparam logic [DIST_W-1:0]   DIST_MAX   = 26'h3FFFFFF;

    localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG7_HALF_TURN = 64'd1800000000;
    localparam logic [63:0] RAD_HI         = PI_Q60 / DEG7_HALF_TURN;
    localparam logic [63:0] RAD_LO         = ((PI_Q60 % DEG7_HALF_TURN) << 31) / DEG7_HALF_TURN;
    localparam logic [63:0] GAIN_Q32       = 64'h9B74EDA8;

    localparam logic [63:0] PI_F64  = (PI_Q60 >> (60 - ANGLE_FRAC_BITS))
                                    + ((PI_Q60 >> (59 - ANGLE_FRAC_BITS)) & 64'd1);
    localparam logic [63:0] HPI_F64 = (PI_Q60 >> (61 - ANGLE_FRAC_BITS))
                                    + ((PI_Q60 >> (60 - ANGLE_FRAC_BITS)) & 64'd1);
    localparam logic [63:0] GAIN_F64 = (GAIN_Q32 >> (32 - ANGLE_FRAC_BITS))
                                     + ((GAIN_Q32 >> (31 - ANGLE_FRAC_BITS)) & 64'd1);

    localparam logic signed [ANG_W-1:0] PI_F   = ANG_W'(PI_F64);
    localparam logic signed [ANG_W-1:0] HPI_F  = ANG_W'(HPI_F64);
    localparam logic signed [ANG_W-1:0] GAIN_F = ANG_W'(GAIN_F64);

    // atan(2^-i) from its power series in Q62, rounded to the angle format
    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [63:0] acc;
        logic [63:0] term;
        logic [63:0] rem;
        logic [63:0] den;
        int pw;
        acc = '0;
        if (i == 0) begin
            acc = $signed(PI_Q60);
        end else begin
            for (int k = 0; k < 64; k++) begin
                den = 64'(2 * k + 1);
                pw  = i * (2 * k + 1);
                if (pw <= 62) begin
                    term = '0;
                    rem  = '0;
                    for (int b = 62; b >= 0; b--) begin
                        rem = (rem << 1) | ((b == 62 - pw) ? 64'd1 : 64'd0);
                        if (rem >= den) begin
                            rem     = rem - den;
                            term[b] = 1'b1;
                        end
                    end
                    acc = (k % 2 == 1) ? acc - $signed(term) : acc + $signed(term);
                end
            end
        end
        acc = (acc + (64'sd1 <<< (61 - ANGLE_FRAC_BITS))) >>> (62 - ANGLE_FRAC_BITS);
        return ANG_W'(acc);
    endfunction

    function automatic int latency(input int steps);
        return 4 + steps + 1 + 4 + SQRT_STEPS + steps + 2;
    endfunction

endpackage

[src/haversine_distance.sv]
// haversine great-circle distance, fully pipelined
// throughput: one request per cycle; busy stays low, results cannot be stalled
// the depth comes from the sin/cos cordic, the 32-stage roots and the atan2 cordic
// reset clears every stage valid bit and loads the radius register with 6371000
module haversine_distance #(
    parameter int CORDIC_STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [hvd_pkg::LAT_W-1:0]       i_start_latitude,
    input  logic signed [hvd_pkg::LON_W-1:0]       i_start_longitude,
    input  logic signed [hvd_pkg::LAT_W-1:0]       i_end_latitude,
    input  logic signed [hvd_pkg::LON_W-1:0]       i_end_longitude,
    input  logic                                   i_cfg_wr_en,
    input  logic [hvd_pkg::RADIUS_W-1:0]           i_cfg_wr_data,
    output logic                                   o_valid,
    output logic [hvd_pkg::DIST_W-1:0]             o_distance_m
);
    import hvd_pkg::*;

    localparam logic signed [ANG_W:0]       Q_ONE  = (ANG_W+1)'(64'd1 << 31);
    localparam logic signed [PROD_W-1:0]    HALF31 = PROD_W'(64'd1 << 30);
    localparam logic signed [UNIT_W:0]      A_ONE  = (UNIT_W+1)'(64'd1 << 31);
    localparam logic [DPROD_W-1:0]          D_RND  = DPROD_W'(64'd1 << (DIST_SH - 1));

    logic [RADIUS_W-1:0] r_radius;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    logic r_s6_valid, r_s7_valid, r_s8_valid, r_s9_valid, r_s10_valid, r_out_valid;

    logic [MAG_W-1:0]        r_s1_mag [4], n_s1_mag [4];
    logic                    r_s1_neg [4], n_s1_neg [4];
    logic [63:0]             r_s2_hi [4], r_s2_lo [4];
    logic                    r_s2_neg [4];
    logic signed [ANG_W-1:0] r_s3_ang [4], n_s3_ang [4];
    logic signed [ANG_W-1:0] r_s4_th [4], n_s4_th [4];
    logic [3:0]              r_s4_flip, n_s4_flip;

    logic                              rot_valid;
    logic [3:0][ANG_W-1:0]             rot_x_in, rot_y_in, rot_z_in;
    logic [3:0][ANG_W-1:0]             rot_x, rot_y, rot_z;
    logic [3:0]                        rot_flip;

    logic signed [UNIT_W-1:0] r_s5_unit [4], n_s5_unit [4];
    logic signed [PROD_W-1:0] r_s6_psl, r_s6_pso, r_s6_pcc;
    logic signed [UNIT_W-1:0] r_s7_sqlat, r_s7_sqlon, r_s7_cc;
    logic signed [PROD_W-1:0] r_s8_pt2;
    logic signed [UNIT_W-1:0] r_s8_sqlat;
    logic [A_W-1:0]           r_s9_a, n_s9_a;

    logic                         sq_valid;
    logic [1:0][SQ_W-1:0]         sq_n;
    logic [1:0][ROOT_W-1:0]       sq_root;
    logic [A_W-1:0]               a_comp;

    logic                    vec_valid;
    logic [0:0][ANG_W-1:0]   vec_x_in, vec_y_in, vec_z_in;
    logic [0:0][ANG_W-1:0]   vec_x, vec_y, vec_z;
    logic [0:0]              vec_tag;

    logic [DPROD_W-1:0]  r_s10_prod, n_s10_prod;
    logic [DIST_W-1:0]   r_dist, n_dist;

    assign busy         = 1'b0;
    assign o_valid      = r_out_valid;
    assign o_distance_m = r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_s9_valid  <= 1'b0;
            r_s10_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= start && !busy;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= rot_valid;
            r_s6_valid  <= r_s5_valid;
            r_s7_valid  <= r_s6_valid;
            r_s8_valid  <= r_s7_valid;
            r_s9_valid  <= r_s8_valid;
            r_s10_valid <= vec_valid;
            r_out_valid <= r_s10_valid;
        end
    end

    // differences and magnitudes: dlat, dlon, lat1, lat2
    always_comb begin
        logic signed [LON_W-1:0] d_lat;
        logic signed [LON_W:0]   d_lon;
        logic signed [LON_W:0]   src [4];
        d_lat  = LON_W'(i_end_latitude) - LON_W'(i_start_latitude);
        d_lon  = (LON_W+1)'(i_end_longitude) - (LON_W+1)'(i_start_longitude);
        src[0] = (LON_W+1)'(d_lat);
        src[1] = d_lon;
        src[2] = (LON_W+1)'(i_start_latitude);
        src[3] = (LON_W+1)'(i_end_latitude);
        for (int k = 0; k < 4; k++) begin
            n_s1_neg[k] = src[k][LON_W];
            n_s1_mag[k] = src[k][LON_W] ? MAG_W'(-src[k]) : MAG_W'(src[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mag <= n_s1_mag;
        r_s1_neg <= n_s1_neg;
        for (int k = 0; k < 4; k++) begin
            r_s2_hi[k]  <= 64'(r_s1_mag[k]) * RAD_HI;
            r_s2_lo[k]  <= 64'(r_s1_mag[k]) * RAD_LO;
            r_s2_neg[k] <= r_s1_neg[k];
        end
        r_s3_ang  <= n_s3_ang;
        r_s4_th   <= n_s4_th;
        r_s4_flip <= n_s4_flip;
    end

    always_comb begin
        logic [63:0] r60;
        logic [63:0] mag;
        int          sh;
        for (int k = 0; k < 4; k++) begin
            r60 = r_s2_hi[k] + (r_s2_lo[k] >> 31);
            sh  = ANGLE_SH + ((k < 2) ? 1 : 0);
            mag = (r60 >> sh) + {63'd0, r60[sh-1]};
            n_s3_ang[k] = r_s2_neg[k] ? -ANG_W'(mag) : ANG_W'(mag);
        end
    end

    // fold into [-pi/2, pi/2]
    always_comb begin
        logic signed [ANG_W-1:0] th;
        logic                    fl;
        for (int k = 0; k < 4; k++) begin
            th = r_s3_ang[k];
            fl = 1'b0;
            for (int j = 0; j < 2; j++) begin
                if (th > HPI_F) begin
                    th = th - PI_F;
                    fl = !fl;
                end else if (th < -HPI_F) begin
                    th = th + PI_F;
                    fl = !fl;
                end
            end
            n_s4_th[k]   = th;
            n_s4_flip[k] = fl;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rot_x_in[k] = GAIN_F;
            rot_y_in[k] = '0;
            rot_z_in[k] = r_s4_th[k];
        end
    end

    hvd_cordic #(
        .STEPS     (CORDIC_STEPS),
        .LANES     (4),
        .VECTORING (1'b0),
        .TAG_W     (4)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_valid),
        .i_x     (rot_x_in),
        .i_y     (rot_y_in),
        .i_z     (rot_z_in),
        .i_tag   (r_s4_flip),
        .o_valid (rot_valid),
        .o_x     (rot_x),
        .o_y     (rot_y),
        .o_z     (rot_z),
        .o_tag   (rot_flip)
    );

    // sines of the half differences, cosines of the latitudes, in q1.31
    always_comb begin
        logic signed [ANG_W-1:0] v;
        logic signed [ANG_W:0]   q;
        logic signed [UNIT_W-1:0] u;
        for (int k = 0; k < 4; k++) begin
            v = (k < 2) ? $signed(rot_y[k]) : $signed(rot_x[k]);
            q = {v, 1'b0};
            if (q > Q_ONE) begin
                q = Q_ONE;
            end else if (q < -Q_ONE) begin
                q = -Q_ONE;
            end
            u = UNIT_W'(q);
            n_s5_unit[k] = rot_flip[k] ? -u : u;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_unit  <= n_s5_unit;
        r_s6_psl   <= r_s5_unit[0] * r_s5_unit[0];
        r_s6_pso   <= r_s5_unit[1] * r_s5_unit[1];
        r_s6_pcc   <= r_s5_unit[2] * r_s5_unit[3];
        r_s7_sqlat <= UNIT_W'(r_s6_psl >>> 31) + {{(UNIT_W-1){1'b0}}, r_s6_psl[30]};
        r_s7_sqlon <= UNIT_W'(r_s6_pso >>> 31) + {{(UNIT_W-1){1'b0}}, r_s6_pso[30]};
        r_s7_cc    <= UNIT_W'((r_s6_pcc + HALF31) >>> 31);
        r_s8_pt2   <= r_s7_cc * r_s7_sqlon;
        r_s8_sqlat <= r_s7_sqlat;
        r_s9_a     <= n_s9_a;
    end

    always_comb begin
        logic signed [UNIT_W-1:0] t2;
        logic signed [UNIT_W:0]   asum;
        t2   = UNIT_W'((r_s8_pt2 + HALF31) >>> 31);
        asum = (UNIT_W+1)'(t2) + (UNIT_W+1)'(r_s8_sqlat);
        if (asum < 0) begin
            n_s9_a = '0;
        end else if (asum > A_ONE) begin
            n_s9_a = A_W'(A_ONE);
        end else begin
            n_s9_a = A_W'(asum);
        end
    end

    assign a_comp   = A_W'(A_ONE) - r_s9_a;
    assign sq_n[0]  = {1'b0, r_s9_a, 31'd0};
    assign sq_n[1]  = {1'b0, a_comp, 31'd0};

    hvd_sqrt #(
        .LANES (2)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s9_valid),
        .i_n     (sq_n),
        .o_valid (sq_valid),
        .o_root  (sq_root)
    );

    assign vec_y_in[0] = {{(ANG_W-ROOT_W){1'b0}}, sq_root[0]};
    assign vec_x_in[0] = {{(ANG_W-ROOT_W){1'b0}}, sq_root[1]};
    assign vec_z_in[0] = '0;

    hvd_cordic #(
        .STEPS     (CORDIC_STEPS),
        .LANES     (1),
        .VECTORING (1'b1),
        .TAG_W     (1)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_x     (vec_x_in),
        .i_y     (vec_y_in),
        .i_z     (vec_z_in),
        .i_tag   (1'b0),
        .o_valid (vec_valid),
        .o_x     (vec_x),
        .o_y     (vec_y),
        .o_z     (vec_z),
        .o_tag   (vec_tag)
    );

    // distance = radius * 2z, rounded
    always_comb begin
        logic [ZC_W-1:0] zc;
        zc = vec_z[0][ANG_W-1] ? '0 : vec_z[0][ZC_W-1:0];
        n_s10_prod = DPROD_W'(r_radius) * DPROD_W'(zc);
    end

    always_comb begin
        logic [DPROD_W-1:0] rnd;
        logic [DPROD_W-1:0] d;
        rnd = r_s10_prod + D_RND;
        d   = rnd >> DIST_SH;
        if (d > DPROD_W'(DIST_MAX)) begin
            n_dist = DIST_MAX;
        end else begin
            n_dist = DIST_W'(d);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s10_prod <= n_s10_prod;
        r_dist     <= n_dist;
    end

endmodule

[src/hvd_cordic.sv]
// pipelined cordic, one micro-rotation per stage, rotation or vectoring mode
module hvd_cordic #(
    parameter int STEPS     = hvd_pkg::CORDIC_STEPS_DEF,
    parameter int LANES     = 1,
    parameter bit VECTORING = 1'b0,
    parameter int TAG_W     = 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [LANES-1:0][hvd_pkg::ANG_W-1:0]   i_x,
    input  logic [LANES-1:0][hvd_pkg::ANG_W-1:0]   i_y,
    input  logic [LANES-1:0][hvd_pkg::ANG_W-1:0]   i_z,
    input  logic [TAG_W-1:0]                       i_tag,
    output logic                                   o_valid,
    output logic [LANES-1:0][hvd_pkg::ANG_W-1:0]   o_x,
    output logic [LANES-1:0][hvd_pkg::ANG_W-1:0]   o_y,
    output logic [LANES-1:0][hvd_pkg::ANG_W-1:0]   o_z,
    output logic [TAG_W-1:0]                       o_tag
);
    import hvd_pkg::*;

    logic signed [ANG_W-1:0] w_x [STEPS+1][LANES];
    logic signed [ANG_W-1:0] w_y [STEPS+1][LANES];
    logic signed [ANG_W-1:0] w_z [STEPS+1][LANES];
    logic                    w_valid [STEPS+1];
    logic [TAG_W-1:0]        w_tag [STEPS+1];

    assign w_valid[0] = i_valid;
    assign w_tag[0]   = i_tag;
    assign o_valid    = w_valid[STEPS];
    assign o_tag      = w_tag[STEPS];

    for (genvar l = 0; l < LANES; l++) begin : g_io
        assign w_x[0][l] = i_x[l];
        assign w_y[0][l] = i_y[l];
        assign w_z[0][l] = i_z[l];
        assign o_x[l]    = w_x[STEPS][l];
        assign o_y[l]    = w_y[STEPS][l];
        assign o_z[l]    = w_z[STEPS][l];
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam logic signed [ANG_W-1:0] ANGLE = atan_entry(s);
        logic             r_valid;
        logic [TAG_W-1:0] r_tag;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= w_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag <= w_tag[s];
        end

        assign w_valid[s+1] = r_valid;
        assign w_tag[s+1]   = r_tag;

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic signed [ANG_W-1:0] r_x, r_y, r_z;
            logic signed [ANG_W-1:0] n_x, n_y, n_z;
            logic signed [ANG_W-1:0] dx, dy;
            logic                    pos;

            always_comb begin
                dx  = w_y[s][l] >>> s;
                dy  = w_x[s][l] >>> s;
                pos = VECTORING ? w_y[s][l][ANG_W-1] : !w_z[s][l][ANG_W-1];
                if (pos) begin
                    n_x = w_x[s][l] - dx;
                    n_y = w_y[s][l] + dy;
                    n_z = w_z[s][l] - ANGLE;
                end else begin
                    n_x = w_x[s][l] + dx;
                    n_y = w_y[s][l] - dy;
                    n_z = w_z[s][l] + ANGLE;
                end
            end

            always_ff @(posedge i_clk) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end

            assign w_x[s+1][l] = r_x;
            assign w_y[s+1][l] = r_y;
            assign w_z[s+1][l] = r_z;
        end
    end

endmodule

[src/hvd_sqrt.sv]
// pipelined shift-and-subtract integer square root, one result bit per stage
module hvd_sqrt #(
    parameter int LANES = 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [LANES-1:0][hvd_pkg::SQ_W-1:0]    i_n,
    output logic                                   o_valid,
    output logic [LANES-1:0][hvd_pkg::ROOT_W-1:0]  o_root
);
    import hvd_pkg::*;

    logic [SQ_W-1:0] w_n   [SQRT_STEPS+1][LANES];
    logic [SQ_W-1:0] w_res [SQRT_STEPS+1][LANES];
    logic            w_valid [SQRT_STEPS+1];

    assign w_valid[0] = i_valid;
    assign o_valid    = w_valid[SQRT_STEPS];

    for (genvar l = 0; l < LANES; l++) begin : g_io
        assign w_n[0][l]   = i_n[l];
        assign w_res[0][l] = '0;
        assign o_root[l]   = w_res[SQRT_STEPS][l][ROOT_W-1:0];
    end

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = 64'd1 << (62 - 2 * s);
        logic r_valid;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= w_valid[s];
            end
        end

        assign w_valid[s+1] = r_valid;

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [SQ_W-1:0] r_n, r_res, n_n, n_res, trial;

            always_comb begin
                trial = w_res[s][l] + BIT;
                if (w_n[s][l] >= trial) begin
                    n_n   = w_n[s][l] - trial;
                    n_res = (w_res[s][l] >> 1) + BIT;
                end else begin
                    n_n   = w_n[s][l];
                    n_res = w_res[s][l] >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                r_n   <= n_n;
                r_res <= n_res;
            end

            assign w_n[s+1][l]   = r_n;
            assign w_res[s+1][l] = r_res;
        end
    end

endmodule

[src/hvd_check.sv]
// port-level checks for haversine_distance and their bind
module hvd_check #(
    parameter int CORDIC_STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic signed [hvd_pkg::LAT_W-1:0]   i_start_latitude,
    input logic signed [hvd_pkg::LON_W-1:0]   i_start_longitude,
    input logic signed [hvd_pkg::LAT_W-1:0]   i_end_latitude,
    input logic signed [hvd_pkg::LON_W-1:0]   i_end_longitude,
    input logic                               o_valid,
    input logic [hvd_pkg::DIST_W-1:0]         o_distance_m
);
    import hvd_pkg::*;

    localparam int LAT = latency(CORDIC_STEPS);

    // every request gives a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("request without result");

    // no result without a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without request");

    // coincident points give a near-zero distance
    a_same_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_start_latitude == i_end_latitude
         && i_start_longitude == i_end_longitude)
        |-> ##LAT (o_distance_m <= 26'd2))
        else $error("coincident points not near zero");

endmodule

bind haversine_distance hvd_check #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_hvd_check (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_start_latitude  (i_start_latitude),
    .i_start_longitude (i_start_longitude),
    .i_end_latitude    (i_end_latitude),
    .i_end_longitude   (i_end_longitude),
    .o_valid           (o_valid),
    .o_distance_m      (o_distance_m)
);

[tb/haversine_distance_checker.sv]
`timescale 1ns / 100ps
// request/result checker with a fixed-point great-circle distance predictor
module haversine_distance_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [hvd_pkg::LAT_W-1:0]    i_start_latitude,
    input  logic signed [hvd_pkg::LON_W-1:0]    i_start_longitude,
    input  logic signed [hvd_pkg::LAT_W-1:0]    i_end_latitude,
    input  logic signed [hvd_pkg::LON_W-1:0]    i_end_longitude,
    input  logic                                i_cfg_wr_en,
    input  logic [hvd_pkg::RADIUS_W-1:0]        i_cfg_wr_data,
    input  logic                                o_valid,
    input  logic [hvd_pkg::DIST_W-1:0]          o_distance_m,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import hvd_pkg::*;

    localparam int FB    = ANGLE_FRAC_BITS;
    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam longint ONE_Q31 = 64'sd1 <<< 31;

    longint                  arctan_q [STEPS];
    logic [RADIUS_W-1:0]     radius_m;
    logic [DIST_W-1:0]       expected_dist [$];
    int                      fails;

    function automatic longint unsigned ushr_round(longint unsigned v, int s);
        return (v >> s) + ((v >> (s - 1)) & 64'd1);
    endfunction

    function automatic longint sshr_round(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v > ONE_Q31) return ONE_Q31;
        if (v < -ONE_Q31) return -ONE_Q31;
        return v;
    endfunction

    function automatic longint to_radians(longint v, int extra);
        longint unsigned m, r60;
        longint mag;
        m   = (v < 0) ? longint'(-v) : longint'(v);
        r60 = m * RAD_HI + ((m * RAD_LO) >> 31);
        mag = longint'(ushr_round(r60, 60 + extra - FB));
        return (v < 0) ? -mag : mag;
    endfunction

    task automatic rotate(input longint ang, output longint sin_q, output longint cos_q);
        longint x, y, dx, dy, th, pi_f, hpi_f;
        bit     flip;
        pi_f  = longint'(ushr_round(PI_Q60, 60 - FB));
        hpi_f = longint'(ushr_round(PI_Q60, 61 - FB));
        th    = ang;
        flip  = 0;
        for (int k = 0; k < 2; k++) begin
            if (th > hpi_f) begin
                th -= pi_f;
                flip = !flip;
            end else if (th < -hpi_f) begin
                th += pi_f;
                flip = !flip;
            end
        end
        x = longint'(ushr_round(GAIN_Q32, 32 - FB));
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (th >= 0) begin
                x -= dx; y += dy; th -= arctan_q[i];
            end else begin
                x += dx; y -= dy; th += arctan_q[i];
            end
        end
        x = unit_clamp(x <<< (31 - FB));
        y = unit_clamp(y <<< (31 - FB));
        sin_q = flip ? -y : y;
        cos_q = flip ? -x : x;
    endtask

    function automatic longint unsigned root_of(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic dist_for_points(input longint lat1, input longint lon1,
                                   input longint lat2, input longint lon2,
                                   input logic [RADIUS_W-1:0] rad,
                                   output logic [DIST_W-1:0] dist_out);
        longint s_lat, s_lon, c1, c2, unused, sq_lat, sq_lon, cc, t2, a, x, y, z, dx, dy;
        logic [127:0] p;
        rotate(to_radians(lat2 - lat1, 1), s_lat, unused);
        rotate(to_radians(lon2 - lon1, 1), s_lon, unused);
        rotate(to_radians(lat1, 0), unused, c1);
        rotate(to_radians(lat2, 0), unused, c2);
        sq_lat = longint'(ushr_round(longint'(s_lat * s_lat), 31));
        sq_lon = longint'(ushr_round(longint'(s_lon * s_lon), 31));
        cc = sshr_round(c1 * c2, 31);
        t2 = sshr_round(cc * sq_lon, 31);
        a  = sq_lat + t2;
        if (a < 0) a = 0;
        if (a > ONE_Q31) a = ONE_Q31;
        y = longint'(root_of(longint'(a) << 31));
        x = longint'(root_of(longint'(ONE_Q31 - a) << 31));
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_q[i];
            end else begin
                x -= dx; y += dy; z -= arctan_q[i];
            end
        end
        if (z < 0) z = 0;
        p = 128'(rad) * 128'(z) + (128'd1 << (DIST_SH - 1));
        p = p >> DIST_SH;
        dist_out = (p > 128'(DIST_MAX)) ? DIST_MAX : p[DIST_W-1:0];
    endtask

    initial begin
        longint unsigned acc, term;
        int pw;
        for (int i = 0; i < STEPS; i++) begin
            if (i == 0) begin
                acc = PI_Q60;
            end else begin
                acc = 0;
                for (int k = 0; k < 64; k++) begin
                    pw = i * (2 * k + 1);
                    if (pw <= 62) begin
                        term = (64'd1 << (62 - pw)) / longint'(2 * k + 1);
                        acc  = (k % 2 == 1) ? acc - term : acc + term;
                    end
                end
            end
            arctan_q[i] = sshr_round(longint'(acc), 62 - FB);
        end
        fails = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        logic [DIST_W-1:0] want;
        if (!i_rst_n) begin
            radius_m <= RADIUS_RST;
            expected_dist.delete();
        end else begin
            if (o_valid) begin
                if (expected_dist.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, actual %0d", $time, o_distance_m);
                end else begin
                    want = expected_dist.pop_front();
                    if (o_distance_m !== want) begin
                        fails++;
                        $display("%0t: distance_m mismatch, expected %0d actual %0d",
                                 $time, want, o_distance_m);
                    end
                end
            end
            if (start && !busy) begin
                dist_for_points(i_start_latitude, i_start_longitude, i_end_latitude,
                                i_end_longitude, radius_m, want);
                expected_dist.push_back(want);
            end
            if (i_cfg_wr_en) radius_m <= i_cfg_wr_data;
        end
        o_pending    <= expected_dist.size();
        o_fail_count <= fails;
    end

endmodule

[tb/haversine_distance_tb.sv]
`timescale 1ns / 100ps
// stimulus, configuration phases and verdict for the haversine distance block
module haversine_distance_tb;
    import hvd_pkg::*;

    localparam int LATENCY    = 43 + 2 * CORDIC_STEPS_DEF;
    localparam int STALL_LIMIT = 4000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic signed [LAT_W-1:0]    i_start_latitude, i_end_latitude;
    logic signed [LON_W-1:0]    i_start_longitude, i_end_longitude;
    logic                       i_cfg_wr_en;
    logic [RADIUS_W-1:0]        i_cfg_wr_data;
    logic                       o_valid;
    logic [DIST_W-1:0]          o_distance_m;
    int                         pending, fail_count, idle_pct, quiet_cycles;

    haversine_distance uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_start_latitude(i_start_latitude), .i_start_longitude(i_start_longitude),
        .i_end_latitude(i_end_latitude), .i_end_longitude(i_end_longitude),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .o_valid(o_valid), .o_distance_m(o_distance_m)
    );

    haversine_distance_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_start_latitude(i_start_latitude), .i_start_longitude(i_start_longitude),
        .i_end_latitude(i_end_latitude), .i_end_longitude(i_end_longitude),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .o_valid(o_valid), .o_distance_m(o_distance_m),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(input longint lat1, input longint lon1,
                            input longint lat2, input longint lon2);
        start             <= 1'b1;
        i_start_latitude  <= lat1[LAT_W-1:0];
        i_start_longitude <= lon1[LON_W-1:0];
        i_end_latitude    <= lat2[LAT_W-1:0];
        i_end_longitude   <= lon2[LON_W-1:0];
        do @(posedge i_clk); while (busy);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_radius(input logic [RADIUS_W-1:0] r);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic longint rand_lat();
        return longint'($urandom_range(1800000000, 0)) - 900000000;
    endfunction

    function automatic longint rand_lon();
        return longint'($urandom_range(32'd3600000000, 0)) - 1800000000;
    endfunction

    task automatic random_reqs(input int count);
        longint lat1, lon1, lat2, lon2;
        for (int n = 0; n < count; n++) begin
            lat1 = rand_lat();
            lon1 = rand_lon();
            case ($urandom_range(9, 0))
                0, 1: begin
                    lat2 = lat1 + $signed($urandom_range(20000, 0)) - 10000;
                    lon2 = lon1 + $signed($urandom_range(20000, 0)) - 10000;
                end
                2: begin
                    lat2 = -lat1;
                    lon2 = (lon1 >= 0) ? lon1 - 1800000000 : lon1 + 1800000000;
                end
                3: begin
                    lat1 = $signed($urandom()) >>> 1;
                    lat2 = $signed($urandom()) >>> 1;
                    lon1 = $signed($urandom());
                    lon2 = $signed($urandom());
                end
                default: begin
                    lat2 = rand_lat();
                    lon2 = rand_lon();
                end
            endcase
            send_req(lat1, lon1, lat2, lon2);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        i_start_latitude  = '0;
        i_start_longitude = '0;
        i_end_latitude    = '0;
        i_end_longitude   = '0;
        quiet_cycles      = 0;
        idle_pct          = 25;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, coincident and antipodal points, out-of-range values
        send_req(0, 0, 0, 0);
        send_req(900000000, 0, -900000000, 0);
        send_req(-900000000, -1800000000, 900000000, 1800000000);
        send_req(0, -1800000000, 0, 1800000000);
        send_req(0, 0, 0, 1800000000);
        send_req(0, 900000000, 0, -900000000);
        send_req(123456789, 987654321, 123456789, 987654321);
        send_req(900000000, 1800000000, 900000000, -1800000000);
        send_req(1, 1, 0, 0);
        send_req(-1073741824, -64'sd2147483648, 1073741823, 2147483647);
        send_req(1073741823, 2147483647, -1073741824, -64'sd2147483648);
        send_req(1073741823, 0, 0, 0);
        send_req(-1073741824, 2147483647, -1073741824, 2147483647);
        send_req(0, -64'sd2147483648, 0, 2147483647);
        send_req(450000000, 450000000, -450000000, -1350000000);
        send_req(-1, -1, 1, 1);

        set_radius(24'd1);
        random_reqs(60);
        set_radius(24'hFFFFFF);
        random_reqs(150);
        idle_pct = 68;
        set_radius(24'($urandom()));
        random_reqs(150);
        set_radius(24'd6371000);
        random_reqs(150);
        idle_pct = 0;
        random_reqs(40);
        set_radius(24'd1000);
        random_reqs(150);

        drain();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
